// ===== hw/rtl/top_k_largest_select_macros.svh =====
// ----------------------------------------------------------------------------
// Top-k select assertion macros
// Shorthand for clocked properties checked against clk, muted during reset.
// ----------------------------------------------------------------------------
`ifndef TOP_K_LARGEST_SELECT_MACROS_SVH
`define TOP_K_LARGEST_SELECT_MACROS_SVH

// Same-cycle implication.
`define TKS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// Top-k select package
// Shared widths, reset value, controller states and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

	localparam int DATA_W = 32;
	localparam int KEEP_W = 5;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP,
		ST_UP_CMP,
		ST_RT_RD,
		ST_RT_CMP,
		ST_DN,
		ST_DN_L,
		ST_DN_R,
		ST_EX_SETUP,
		ST_EX_RD,
		ST_EX_ROOT,
		ST_EX_EMIT,
		ST_EX_LAST,
		ST_EX_LOAD
	} tks_state_t;

	// One result word handed from the heap controller to the output register.
	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] value;
		logic                     last_flag;
	} tks_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/top_k_largest_select.sv =====
// ----------------------------------------------------------------------------
// Top-k largest select
// Keeps the largest values of each set in a RAM min-heap and reports them
// smallest first when the set ends.
// ----------------------------------------------------------------------------
//
//  Port group   Dir  Bits  Contents (low bit first)
//  s_*          in   32+1  tdata: sample_value; tlast: set_end
//  m_*          out  32+1  tdata: kept_value; tlast: final_result
//  cfg_*        in   5     keep_count, written when cfg_we is high
//
//  One value at a time: one that does not beat the heap minimum is compared
//  with the root and dropped; an appended one climbs level by level; one that
//  displaces the minimum sinks level by level, the heap RAM's single read port
//  setting the pace. At set end, after a setup step, each held value is read
//  from the root and reported, and the last entry is reloaded and sunk.
//  Reset empties the heap count and sets keep_count to 5; the RAM is not
//  cleared. A stalled m_tready holds the drain, and s_tready stays low.
//
`default_nettype none

`include "top_k_largest_select_macros.svh"

module top_k_largest_select #(
	parameter int MAX_KEEP = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// sample_value
	input  wire logic signed [tks_pkg::DATA_W-1:0] s_tdata,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// set_end
	input  wire logic                              s_tlast,
	// kept_value
	output logic signed [tks_pkg::DATA_W-1:0]      m_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// final_result
	output logic                                   m_tlast,
	input  wire logic                              cfg_we,
	input  wire logic [tks_pkg::KEEP_W-1:0]        cfg_wdata
);

	logic [tks_pkg::KEEP_W-1:0] keep_count_q;
	tks_pkg::tks_word_t         push;
	logic                       out_free;

	// Keep count register: hold until rewritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= tks_pkg::KEEP_RESET;
		end else if (cfg_we) begin
			keep_count_q <= cfg_wdata;
		end
	end

	// Heap engine: owns the value RAM and the held count.
	tks_heap_ctrl #(
		.MAX_KEEP (MAX_KEEP)
	) u_heap_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.keep_count (keep_count_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.out_free   (out_free),
		.push       (push)
	);

	// Output word register: parts the drain from the downstream stall.
	tks_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	`TKS_ASSERT_IMPL(a_push_free, push.valid, out_free, "result pushed into a busy slot")
	`TKS_ASSERT_IMPL(a_push_busy, push.valid, !s_tready, "result pushed while idle")
	`TKS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second word taken early")

endmodule

`default_nettype wire

// ===== hw/rtl/tks_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tks_out_reg.sv =====
// ----------------------------------------------------------------------------
// Top-k select output register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_out_reg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tks_pkg::tks_word_t                push,
	output logic                                   free,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic signed [tks_pkg::DATA_W-1:0]      m_tdata,
	output logic                                   m_tlast
);

	logic                              valid_q;
	logic signed [tks_pkg::DATA_W-1:0] data_q;
	logic                              last_q;

	// Slot may be refilled in the cycle its word leaves.
	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push.valid) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			data_q <= push.value;
			last_q <= push.last_flag;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tks_heap_ctrl.sv =====
// ----------------------------------------------------------------------------
// Top-k select heap controller
// Min-heap kept in RAM: append with sift-up, replace root with sift-down,
// drain by repeated root extraction at set end.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_heap_ctrl #(
	parameter int MAX_KEEP = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [tks_pkg::KEEP_W-1:0]        keep_count,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic signed [tks_pkg::DATA_W-1:0] s_tdata,
	input  wire logic                              s_tlast,
	input  wire logic                              out_free,
	output tks_pkg::tks_word_t                     push
);

	localparam int CW = $clog2(MAX_KEEP + 1);
	localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int IW = CW + 1;

	tks_pkg::tks_state_t state_q, state_d, done_state;

	logic [CW-1:0]                     cnt_q, cnt_d;
	logic [CW-1:0]                     drop_q, drop_d;
	logic                              extr_q, extr_d;
	logic                              last_q, last_d;
	logic [AW-1:0]                     pos_q, pos_d;
	logic signed [tks_pkg::DATA_W-1:0] val_q, val_d;
	logic signed [tks_pkg::DATA_W-1:0] lv_q, lv_d;
	logic signed [tks_pkg::DATA_W-1:0] root_q, root_d;

	logic                              ram_we, ram_re;
	logic [AW-1:0]                     ram_waddr, ram_raddr;
	logic signed [tks_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

	logic [CW-1:0]                     k_eff;
	logic [AW-1:0]                     parent_a;
	logic [IW-1:0]                     l_w, r_w;
	logic                              r_smaller;
	logic [AW-1:0]                     c_a;
	logic signed [tks_pkg::DATA_W-1:0] c_v;

	tks_ram #(
		.WIDTH (tks_pkg::DATA_W),
		.DEPTH (MAX_KEEP)
	) u_heap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Clamp the requested count into one to MAX_KEEP.
	always_comb begin
		if (keep_count == '0) begin
			k_eff = CW'(1);
		end else if (int'(keep_count) > MAX_KEEP) begin
			k_eff = CW'(MAX_KEEP);
		end else begin
			k_eff = CW'(keep_count);
		end
	end

	assign parent_a  = AW'((pos_q - AW'(1)) >> 1);
	assign l_w       = IW'({pos_q, 1'b1});
	assign r_w       = l_w + IW'(1);
	assign r_smaller = ram_rdata < lv_q;
	assign c_a       = r_smaller ? r_w[AW-1:0] : l_w[AW-1:0];
	assign c_v       = r_smaller ? ram_rdata : lv_q;

	always_comb begin
		if (extr_q) begin
			done_state = tks_pkg::ST_EX_RD;
		end else if (last_q) begin
			done_state = tks_pkg::ST_EX_SETUP;
		end else begin
			done_state = tks_pkg::ST_IDLE;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		drop_d    = drop_q;
		extr_d    = extr_q;
		last_d    = last_q;
		pos_d     = pos_q;
		val_d     = val_q;
		lv_d      = lv_q;
		root_d    = root_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		s_tready  = 1'b0;
		push      = '0;
		case (state_q)
			tks_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					val_d  = s_tdata;
					last_d = s_tlast;
					if (cnt_q < k_eff) begin
						pos_d   = cnt_q[AW-1:0];
						cnt_d   = cnt_q + CW'(1);
						state_d = tks_pkg::ST_UP;
					end else begin
						state_d = tks_pkg::ST_RT_RD;
					end
				end
			end
			tks_pkg::ST_UP: begin
				if (pos_q == '0) begin
					ram_we  = 1'b1;
					state_d = done_state;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = parent_a;
					state_d   = tks_pkg::ST_UP_CMP;
				end
			end
			tks_pkg::ST_UP_CMP: begin
				ram_we = 1'b1;
				if (ram_rdata > val_q) begin
					ram_wdata = ram_rdata;
					pos_d     = parent_a;
					state_d   = tks_pkg::ST_UP;
				end else begin
					state_d = done_state;
				end
			end
			tks_pkg::ST_RT_RD: begin
				ram_re  = 1'b1;
				state_d = tks_pkg::ST_RT_CMP;
			end
			tks_pkg::ST_RT_CMP: begin
				if (val_q > ram_rdata) begin
					pos_d   = '0;
					state_d = tks_pkg::ST_DN;
				end else begin
					state_d = done_state;
				end
			end
			tks_pkg::ST_DN: begin
				if (l_w >= IW'(cnt_q)) begin
					ram_we  = 1'b1;
					state_d = done_state;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = l_w[AW-1:0];
					state_d   = tks_pkg::ST_DN_L;
				end
			end
			tks_pkg::ST_DN_L: begin
				lv_d = ram_rdata;
				if (r_w < IW'(cnt_q)) begin
					ram_re    = 1'b1;
					ram_raddr = r_w[AW-1:0];
					state_d   = tks_pkg::ST_DN_R;
				end else if (ram_rdata < val_q) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					pos_d     = l_w[AW-1:0];
					state_d   = tks_pkg::ST_DN;
				end else begin
					ram_we  = 1'b1;
					state_d = done_state;
				end
			end
			tks_pkg::ST_DN_R: begin
				ram_we = 1'b1;
				if (c_v < val_q) begin
					ram_wdata = c_v;
					pos_d     = c_a;
					state_d   = tks_pkg::ST_DN;
				end else begin
					state_d = done_state;
				end
			end
			tks_pkg::ST_EX_SETUP: begin
				// Surplus entries left by a lowered count are drained unseen.
				drop_d  = (cnt_q > k_eff) ? cnt_q - k_eff : '0;
				extr_d  = 1'b1;
				state_d = tks_pkg::ST_EX_RD;
			end
			tks_pkg::ST_EX_RD: begin
				ram_re  = 1'b1;
				state_d = tks_pkg::ST_EX_ROOT;
			end
			tks_pkg::ST_EX_ROOT: begin
				root_d  = ram_rdata;
				state_d = tks_pkg::ST_EX_EMIT;
			end
			tks_pkg::ST_EX_EMIT: begin
				if (drop_q != '0) begin
					drop_d  = drop_q - CW'(1);
					state_d = tks_pkg::ST_EX_LAST;
				end else if (out_free) begin
					push.valid     = 1'b1;
					push.value     = root_q;
					push.last_flag = (cnt_q == CW'(1));
					state_d        = tks_pkg::ST_EX_LAST;
				end
			end
			tks_pkg::ST_EX_LAST: begin
				cnt_d = cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					extr_d  = 1'b0;
					state_d = tks_pkg::ST_IDLE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = AW'(cnt_q - CW'(1));
					state_d   = tks_pkg::ST_EX_LOAD;
				end
			end
			tks_pkg::ST_EX_LOAD: begin
				val_d   = ram_rdata;
				pos_d   = '0;
				state_d = tks_pkg::ST_DN;
			end
			default: begin
				state_d = tks_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tks_pkg::ST_IDLE;
			cnt_q   <= '0;
			drop_q  <= '0;
			extr_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			drop_q  <= drop_d;
			extr_q  <= extr_d;
			last_q  <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		val_q  <= val_d;
		lv_q   <= lv_d;
		root_q <= root_d;
	end

endmodule

`default_nettype wire

// ===== dv/top_k_largest_select_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k largest select testbench
// Streams sets of signed values into the block under random sender bursts and
// receiver stalls, changes keep_count between sets and in mid-set while the
// block is quiet, and checks every reported word against a local prediction
// of the largest values held per set.
// ----------------------------------------------------------------------------
module top_k_largest_select_test;

	localparam int DATA_W = tks_pkg::DATA_W;
	localparam int KEEP_W = tks_pkg::KEEP_W;
	localparam logic [KEEP_W-1:0] KEEP_RESET = tks_pkg::KEEP_RESET;

	localparam int MAX_KEEP = 16;
	localparam int RAND_ITEMS = 90;
	// Covers one value climbing a full heap, with margin.
	localparam int SETTLE_CYCLES = 48;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 40;

	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam int READY_ALWAYS = 0;
	localparam int READY_RANDOM = 1;
	localparam int READY_MASK = 2;

	// Prediction of the held set and the queue of words still owed by the block.
	class kept_value_board;
		typedef struct packed {
			logic signed [DATA_W-1:0] value;
			logic                     final_flag;
		} kept_word_t;

		logic signed [DATA_W-1:0] held [MAX_KEEP];
		int                       held_n;
		logic [KEEP_W-1:0]        keep_reg;
		kept_word_t               owed [$];
		int                       errors;

		function new();
			held_n = 0;
			keep_reg = KEEP_RESET;
			errors = 0;
		endfunction

		function void set_keep(input logic [KEEP_W-1:0] k);
			keep_reg = k;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Fold one accepted value into the held set; at set end, queue the report.
		function void note_sample(input logic signed [DATA_W-1:0] v, input logic set_end);
			logic signed [DATA_W-1:0] ordered [MAX_KEEP];
			logic signed [DATA_W-1:0] x;
			kept_word_t               w;
			int                       k;
			int                       mi;
			int                       j;
			int                       first;
			// zero means one, anything above the heap size saturates
			k = (keep_reg == 0) ? 1 : int'(keep_reg);
			if (k > MAX_KEEP) k = MAX_KEEP;
			if (held_n < k) begin
				held[held_n] = v;
				held_n++;
			end else if (held_n > 0) begin
				mi = 0;
				for (int i = 1; i < held_n; i++)
					if (held[i] < held[mi]) mi = i;
				// a tie with the minimum is dropped
				if (v > held[mi]) held[mi] = v;
			end
			if (!set_end) return;
			for (int i = 0; i < held_n; i++) begin
				x = held[i];
				j = i;
				while (j > 0 && ordered[j-1] > x) begin
					ordered[j] = ordered[j-1];
					j--;
				end
				ordered[j] = x;
			end
			// after a lowered keep_count only the largest k are reported
			first = (held_n > k) ? held_n - k : 0;
			for (int i = first; i < held_n; i++) begin
				w.value = ordered[i];
				w.final_flag = (i == held_n - 1);
				owed = {owed, w};
			end
			held_n = 0;
		endfunction

		function void check_word(input logic signed [DATA_W-1:0] v, input logic fl);
			kept_word_t w;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected word, expected none, actual %0d last %0b",
						$time, v, fl);
				return;
			end
			w = owed.pop_front();
			if (w.value !== v) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: kept_value mismatch, expected %0d, actual %0d",
						$time, w.value, v);
			end
			if (w.final_flag !== fl) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: final_result mismatch, expected %0b, actual %0b",
						$time, w.final_flag, fl);
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic signed [DATA_W-1:0] s_tdata = '0;   // sample_value
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic                     s_tlast = 1'b0;  // set_end
	logic signed [DATA_W-1:0] m_tdata;        // kept_value
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic                     m_tlast;        // final_result
	logic                     cfg_we = 1'b0;
	logic [KEEP_W-1:0]        cfg_wdata = '0;

	kept_value_board sb;
	int              burst_left = 0;
	int unsigned     cycle_count = 0;
	int              ready_mode = READY_ALWAYS;
	int              mode_left = 0;
	logic [7:0]      stall_mask = 8'h01;

	top_k_largest_select #(
		.MAX_KEEP(MAX_KEEP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: switch between always ready, coin flips and a rotating stall mask.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode = $urandom_range(READY_ALWAYS, READY_MASK);
			mode_left = $urandom_range(20, 120);
			stall_mask = 8'($urandom) | 8'h01;
		end else begin
			mode_left--;
		end
		case (ready_mode)
			READY_ALWAYS: begin
				m_tready <= 1'b1;
			end
			READY_RANDOM: begin
				m_tready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				m_tready <= stall_mask[0];
				stall_mask = {stall_mask[0], stall_mask[7:1]};
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tlast);
	end

	// Offer one word; bursts of random length with idle gaps between them.
	task automatic send_sample(input logic signed [DATA_W-1:0] v, input logic last);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		s_tdata <= v;
		s_tlast <= last;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_sample(v, last);
		burst_left--;
		if (burst_left == 0) s_tvalid <= 1'b0;
	endtask

	// Hold the sender until every owed word is out and the heap has settled.
	task automatic wait_idle();
		// a finished burst has already dropped tvalid
		if (burst_left != 0) s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_keep(input logic [KEEP_W-1:0] k);
		cfg_wdata <= k;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_keep(k);
		@(posedge clk);
	endtask

	initial begin
		logic signed [DATA_W-1:0] sample;
		logic [KEEP_W-1:0]        k;
		int                       sent;
		int                       set_left;
		int                       phase_left;

		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Short set at the reset keep_count, with both extremes and zero.
		send_sample(VAL_MIN, 1'b0);
		send_sample(VAL_MAX, 1'b0);
		send_sample('0, 1'b1);
		// Fill, drop a tie with the minimum, then displace the minimum.
		for (int i = 1; i <= 5; i++) send_sample(i, 1'b0);
		send_sample(1, 1'b0);
		send_sample(6, 1'b1);
		wait_idle();

		// Zero keep_count behaves as one.
		write_keep(KEEP_W'(0));
		send_sample(-1, 1'b0);
		send_sample(7, 1'b1);
		wait_idle();

		// Lower keep_count in mid-set: held values stay, only the top one is reported.
		write_keep(KEEP_W'(2));
		send_sample(10, 1'b0);
		send_sample(20, 1'b0);
		send_sample(30, 1'b0);
		wait_idle();
		write_keep(KEEP_W'(1));
		send_sample(25, 1'b1);
		wait_idle();

		// Raise keep_count in mid-set: further values are appended.
		send_sample(3, 1'b0);
		wait_idle();
		write_keep(KEEP_W'(3));
		send_sample(1, 1'b0);
		send_sample(2, 1'b1);
		wait_idle();

		// Oversized keep_count saturates; single-value set.
		write_keep(KEEP_W'(31));
		send_sample(VAL_MIN, 1'b1);

		// Random phases; sets run across phase boundaries to catch mid-set writes.
		sent = 0;
		set_left = 0;
		while (sent < RAND_ITEMS) begin
			wait_idle();
			case ($urandom_range(0, 6))
				0: k = KEEP_W'(0);
				1: k = KEEP_W'(1);
				2: k = KEEP_W'(2);
				3: k = KEEP_W'(16);
				4: k = KEEP_W'(31);
				default: k = KEEP_W'($urandom_range(0, 31));
			endcase
			write_keep(k);
			phase_left = $urandom_range(6, 20);
			while (phase_left > 0 && sent < RAND_ITEMS) begin
				if (set_left == 0)
					set_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24)
						: $urandom_range(1, 7);
				set_left--;
				case ($urandom_range(0, 9))
					0, 1, 2, 3: sample = $urandom;
					4, 5, 6: sample = $signed($urandom_range(0, 15)) - 8;
					7: sample = ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
					default: sample = $signed($urandom_range(0, 1000)) - 500;
				endcase
				send_sample(sample, set_left == 0);
				sent++;
				phase_left--;
			end
		end

		// Drain; a trailing open set owes nothing.
		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tks_pkg.sv
hw/rtl/tks_ram.sv
hw/rtl/tks_out_reg.sv
hw/rtl/tks_heap_ctrl.sv
hw/rtl/top_k_largest_select.sv
dv/top_k_largest_select_test.sv
